// ===== src/rld_pkg.sv =====
// ---------------------------------------------------------------------------
// rld_pkg
// Types, constants and the per-byte decision function of the run-length
// lookahead decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

  localparam logic [7:0] LINE_FEED  = 8'd10;
  localparam logic [7:0] CARR_RET   = 8'd13;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;

  // result queue depth; one request can push up to three runs
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_PUSH    = 3;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_stream;
  } code_t;

  typedef struct packed {
    logic [7:0] run_value;
    logic [6:0] run_length;
    logic       final_run;
  } run_t;

  typedef struct packed {
    logic [1:0] used;
    logic       has;
    logic [7:0] val;
    logic [6:0] len;
  } decision_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= UPPER_A) && (c <= UPPER_Z)) || ((c >= LOWER_A) && (c <= LOWER_Z));
  endfunction

  // Decide on the head byte b0 with k valid bytes in the window (k >= 1).
  function automatic decision_t rld_decide(input logic [7:0] b0, input logic [7:0] w1,
                                           input logic [7:0] w2, input logic [1:0] k);
    decision_t  d;
    logic [7:0] b1;
    logic [7:0] b2;
    b1 = (k > 2'd1) ? w1 : 8'd0;
    b2 = (k > 2'd2) ? w2 : 8'd0;
    d  = '0;
    d.used = 2'd1;
    if ((b0 == LINE_FEED) || (b0 == CARR_RET)) begin
      if (is_letter(b1) && (b2 != b1)) begin
        d.val  = b1;
        d.len  = b0[6:0];
        d.has  = 1'b1;
        d.used = 2'd2;
      end else begin
        d.val = b0;
        d.len = 7'd1;
        d.has = 1'b1;
      end
    end else if (is_letter(b0)) begin
      if (b1 == b0) begin
        d.val  = b0;
        d.len  = b0[6:0];
        d.has  = 1'b1;
        d.used = 2'd2;
      end else begin
        d.val = b0;
        d.len = 7'd1;
        d.has = 1'b1;
      end
    end else if (k >= 2'd2) begin
      // count byte; negative counts give nothing but still eat both bytes
      if (!b0[7]) begin
        d.val = b1;
        d.len = b0[6:0];
        d.has = 1'b1;
      end
      d.used = 2'd2;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/rle_lookahead_decoder.sv =====
// ---------------------------------------------------------------------------
// rle_lookahead_decoder
// Run-length decoder with a two-byte lookahead window; emits (value, length)
// runs through a four-entry result queue.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  code    | in        | code_valid / code_stall | code_t: byte, end mark
//  run     | out       | run_valid / run_stall   | run_t: value, length, final
//
//  A code request is decoded in the cycle it is accepted; its runs are in the
//  result queue the next cycle, behind older runs. One request per cycle while
//  code_stall is low. An end-of-stream request pushes up to three runs, which
//  drain one per cycle while run_stall is low; code_stall rises while fewer
//  than three queue entries are free. Synchronous reset clears the window,
//  the stop flag and the queue.
`default_nettype none

module rle_lookahead_decoder
  import rld_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   code_valid,
  output logic  code_stall,
  input  code_t code,
  output logic  run_valid,
  input  wire   run_stall,
  output run_t  run
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // window state
  logic [7:0] la [2];
  logic [1:0] la_cnt;
  logic       stopped;

  logic [7:0] la_next [2];
  logic [1:0] la_cnt_next;
  logic       stopped_next;

  // result queue
  run_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic       accept;
  logic       pop;
  logic [1:0] n_res;
  run_t       res [4];
  logic [PTR_W-1:0] slot_off [QUEUE_DEPTH];

  // decode
  logic [7:0]  w [3];
  logic [1:0]  k;
  logic [1:0]  cnt_sat;
  logic [1:0]  used;
  logic        stop;
  decision_t   d;

  always_comb begin
    stop    = stopped;
    w[0]    = 8'd0;
    w[1]    = 8'd0;
    w[2]    = 8'd0;
    k       = 2'd0;
    n_res   = 2'd0;
    used    = 2'd0;
    d       = '0;
    res[0]  = '0;
    res[1]  = '0;
    res[2]  = '0;
    res[3]  = '0;
    cnt_sat = (la_cnt > 2'd2) ? 2'd2 : la_cnt;
    if (!stopped) begin
      w[0]       = la[0];
      w[1]       = la[1];
      w[cnt_sat] = code.code_byte;
      k          = cnt_sat + 2'd1;
    end
    // at most three decisions per request, each eats one or two bytes
    for (int i = 0; i < 3; i++) begin
      if (!stop && (k != 2'd0) && ((k == 2'd3) || code.end_of_stream)) begin
        if (w[0] == 8'd0) begin
          stop = 1'b1;
          k    = 2'd0;
        end else begin
          d = rld_decide(w[0], w[1], w[2], k);
          if (d.has) begin
            res[n_res] = '{run_value: d.val, run_length: d.len, final_run: 1'b0};
            n_res      = n_res + 2'd1;
          end
          used = (d.used > k) ? k : d.used;
          if (used == 2'd1) begin
            w[0] = w[1];
            w[1] = w[2];
            w[2] = 8'd0;
          end else if (used == 2'd2) begin
            w[0] = w[2];
            w[1] = 8'd0;
            w[2] = 8'd0;
          end
          k = k - used;
        end
      end
    end
    if (code.end_of_stream) begin
      if (n_res == 2'd0) begin
        res[0] = '{run_value: 8'd0, run_length: 7'd0, final_run: 1'b1};
        n_res  = 2'd1;
      end else begin
        res[n_res - 2'd1].final_run = 1'b1;
      end
    end
  end

  always_comb begin
    if (code.end_of_stream) begin
      la_next[0]   = 8'd0;
      la_next[1]   = 8'd0;
      la_cnt_next  = 2'd0;
      stopped_next = 1'b0;
    end else if (stop) begin
      la_next[0]   = 8'd0;
      la_next[1]   = 8'd0;
      la_cnt_next  = 2'd0;
      stopped_next = 1'b1;
    end else begin
      la_next[0]   = w[0];
      la_next[1]   = w[1];
      la_cnt_next  = (k > 2'd2) ? 2'd2 : k;
      stopped_next = 1'b0;
    end
  end

  assign code_stall = (count > CNT_W'(QUEUE_DEPTH - MAX_PUSH));
  assign accept     = code_valid && !code_stall;
  assign run_valid  = (count != '0);
  assign pop        = run_valid && !run_stall;
  assign run        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      la[0]   <= 8'd0;
      la[1]   <= 8'd0;
      la_cnt  <= 2'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      la[0]   <= la_next[0];
      la[1]   <= la_next[1];
      la_cnt  <= la_cnt_next;
      stopped <= stopped_next;
    end
  end

  // each queue entry knows its distance from the write pointer
  always_comb begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      slot_off[e] = PTR_W'(e) - wr_ptr;
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      if (accept && (slot_off[e] < PTR_W'(n_res))) begin
        queue[e] <= res[slot_off[e][1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (accept ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/rld_checker.sv =====
// ---------------------------------------------------------------------------
// rld_checker
// Port-level checks for the run-length lookahead decoder, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module rld_checker
  import rld_pkg::*;
(
  input wire   clk,
  input wire   rst,
  input wire   code_valid,
  input wire   code_stall,
  input code_t code,
  input wire   run_valid,
  input wire   run_stall,
  input run_t  run
);

  // hold a stalled result
  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_stall |=> run_valid && $stable(run))
    else $error("run result dropped or changed while stalled");

  a_run_valid_stays: assert property (@(posedge clk) disable iff (rst)
    run_valid && run_stall |=> run_valid)
    else $error("run_valid fell while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !run_valid)
    else $error("result shown right after reset");

  // an end request always leaves at least one run behind
  a_end_gives_run: assert property (@(posedge clk) disable iff (rst)
    code_valid && !code_stall && code.end_of_stream |=> run_valid)
    else $error("end of stream produced no run");

  // a zero-length run is only the empty end marker
  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    run_valid && (run.run_length == 7'd0) |-> run.final_run && (run.run_value == 8'd0))
    else $error("zero-length run that is not the end marker");

endmodule

bind rle_lookahead_decoder rld_checker u_rld_checker (
  .clk        (clk),
  .rst        (rst),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code       (code),
  .run_valid  (run_valid),
  .run_stall  (run_stall),
  .run        (run)
);

`default_nettype wire
